/* hdl/sipq_pkg.sv */
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; imported by sipq_cell and sorted_insert_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package sipq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int VALUE_W         = 32;
    localparam int OCC_W           = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic                      ins_en;
        logic                      del_en;
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/sipq_cell.sv */
// One slot of the queue: holds an entry, compares it with the new key and
// shifts to or from its neighbours. Depends on sipq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sipq_cell
    import sipq_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
)
(
    input  wire logic                      clk,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic [CNT_W-1:0]          count,
    input  wire logic signed [VALUE_W-1:0] prev_entry,
    input  wire logic                      prev_greater,
    input  wire logic signed [VALUE_W-1:0] next_entry,
    output logic signed [VALUE_W-1:0]      entry,
    output logic                           greater
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      occupied;
    logic                      tail;

    assign occupied = (CNT_W'(IDX) < count);
    assign tail     = (count == CNT_W'(IDX));
    assign greater  = occupied && ($signed(entry_reg) > $signed(ctrl.key));
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.del_en)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.ins_en)
        begin
            if (prev_greater)
            begin
                entry_next = prev_entry;
            end
            else if (greater || tail)
            begin
                entry_next = ctrl.key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* hdl/sorted_insert_priority_queue.sv */
// Sorted-insert priority queue: a row of compare-and-shift cells plus a count.
// One request accepted per cycle; its response is registered and appears in the
// cycle after acceptance. The whole row updates in the accepting cycle, so the
// next request may follow at once. An unread response holds off new requests.
// Reset clears the count and the response valid; cell contents are not reset.
// Depends on sipq_pkg and sipq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_priority_queue
    import sipq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic                      fire;
    logic                      full;
    logic                      empty;
    logic                      is_del;
    cell_ctrl_t                ctrl;
    logic [CW+OCC_W-1:0]       occ_ext;
    logic signed [VALUE_W-1:0] cell_entry [QUEUE_DEPTH];
    logic                      cell_greater [QUEUE_DEPTH];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign is_del    = (req.kind == KIND_DELETE);

    assign ctrl.ins_en = fire && !is_del && !full;
    assign ctrl.del_en = fire && is_del && !empty;
    assign ctrl.key    = req.value;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] prev_e;
        logic                      prev_g;
        logic signed [VALUE_W-1:0] next_e;

        if (i == 0)
        begin : g_head
            assign prev_e = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_g = cell_greater[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_e = cell_entry[i];
        end
        else
        begin : g_body
            assign next_e = cell_entry[i+1];
        end

        sipq_cell #(
            .CNT_W (CW),
            .IDX   (i)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .count        (count_reg),
            .prev_entry   (prev_e),
            .prev_greater (prev_g),
            .next_entry   (next_e),
            .entry        (cell_entry[i]),
            .greater      (cell_greater[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.del_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign occ_ext = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next              = rsp_reg;
        rsp_next.result_value = '0;
        rsp_next.status       = ST_OK;
        rsp_next.occupancy    = occ_ext[OCC_W-1:0];
        if (is_del)
        begin
            if (empty)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else
            begin
                rsp_next.result_value = cell_entry[0];
            end
        end
        else if (full)
        begin
            rsp_next.status = ST_FULL;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("count exceeds depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow count");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.del_en && count_reg > CW'(1))
        |=> $signed(rsp.result_value) <= $signed(cell_entry[0]))
        else $error("new head smaller than removed entry");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_del && full) |=> rsp.status == ST_FULL)
        else $error("full insert not refused");
`endif

endmodule

`default_nettype wire
